// ===== hdl/sbwa_pkg.sv =====
package sbwa_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam int ADDR_W = 48;
  localparam int STAMP_W = 32;
  localparam int ATT_W = 16;
  localparam int REG_W = 16;
  localparam int COUNT_W = 6;
  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ATTEMPTS = CFG_INDEX_W'(1);

  localparam logic [REG_W-1:0] TIMEOUT_RESET = REG_W'(60);
  localparam logic [REG_W-1:0] MAX_ATTEMPTS_RESET = REG_W'(3);

  localparam logic [ATT_W-1:0] ATT_MAX = {ATT_W{1'b1}};

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [STAMP_W-1:0] stamp;
    logic [ATT_W-1:0]   attempts;
  } entry_t;

endpackage

// ===== hdl/station_blocklist_with_aging.sv =====
// Channel  Beat signals             Payload
// in       in_valid / in_ready      operation, station_addr, connect_request
// out      out_valid / out_ready    verdict, entry_count, removed_count
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Add, check and a tick that fires the prune timer sweep the entry memory, one
// read per cycle, and give their result once the sweep ends and the output
// register is free. Any other item goes straight from idle to the done state.
// One item at a time; in_ready is high only while no item is in progress.
// A result waiting in the output register holds back only the write-back of
// the next item. Reset clears all valid bits at once; no clearing pass.
module station_blocklist_with_aging (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic [sbwa_pkg::ADDR_W-1:0]      station_addr,
  input  logic                             connect_request,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             verdict,
  output logic [sbwa_pkg::COUNT_W-1:0]     entry_count,
  output logic [sbwa_pkg::COUNT_W-1:0]     removed_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbwa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbwa_pkg::REG_W-1:0]       cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;

  logic [sbwa_pkg::REG_W-1:0] timeout_seconds;
  logic [sbwa_pkg::REG_W-1:0] max_attempts;

  logic [sbwa_pkg::DEPTH-1:0]   entry_valid;
  logic [sbwa_pkg::CNT_W-1:0]   valid_total;
  logic [sbwa_pkg::STAMP_W-1:0] now_seconds;
  logic [sbwa_pkg::REG_W-1:0]   prune_countdown;
  logic                         prune_armed;

  // item held for the sweep
  logic [1:0]                  item_op;
  logic [sbwa_pkg::ADDR_W-1:0] item_addr;
  logic                        item_connect;
  logic                        pruning;

  // sweep
  logic [sbwa_pkg::CNT_W-1:0] scan_idx;
  logic                       pend;
  logic [sbwa_pkg::IDX_W-1:0] pend_idx;
  logic                       found;
  logic [sbwa_pkg::IDX_W-1:0] found_idx;
  sbwa_pkg::entry_t           found_entry;
  logic                       free_found;
  logic [sbwa_pkg::IDX_W-1:0] free_idx;
  logic [sbwa_pkg::CNT_W-1:0] removed;

  // entry memory
  sbwa_pkg::entry_t mem [sbwa_pkg::DEPTH];
  sbwa_pkg::entry_t rd_entry;
  logic                       rd_en;
  logic [sbwa_pkg::IDX_W-1:0] rd_idx;
  logic                       wr_en;
  logic [sbwa_pkg::IDX_W-1:0] wr_idx;
  sbwa_pkg::entry_t           wr_entry;

  // write-back decision
  logic                         fire;
  logic                         verdict_next;
  logic [sbwa_pkg::CNT_W-1:0]   valid_total_next;
  logic                         prune_armed_next;
  logic [sbwa_pkg::REG_W-1:0]   prune_countdown_next;
  logic                         set_valid;
  logic [sbwa_pkg::ATT_W-1:0]   att_inc;
  logic [sbwa_pkg::STAMP_W-1:0] age;
  logic                         addr_hit;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign rd_en  = (state == S_SCAN) && (scan_idx < sbwa_pkg::DEPTH_CNT);
  assign rd_idx = scan_idx[sbwa_pkg::IDX_W-1:0];

  assign age      = now_seconds - rd_entry.stamp;
  assign addr_hit = entry_valid[pend_idx] && (rd_entry.addr == item_addr);

  assign fire = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_idx];
    end
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  always_comb begin
    wr_en                = 1'b0;
    wr_idx               = found_idx;
    wr_entry             = found_entry;
    verdict_next         = 1'b0;
    valid_total_next     = valid_total;
    prune_armed_next     = prune_armed;
    prune_countdown_next = prune_countdown;
    set_valid            = 1'b0;
    att_inc              = (found_entry.attempts == sbwa_pkg::ATT_MAX) ?
                           found_entry.attempts : found_entry.attempts + 1'b1;
    case (item_op)
      sbwa_pkg::OP_TICK: begin
        if (pruning) begin
          valid_total_next = valid_total - removed;
          if (valid_total_next == '0) begin
            prune_armed_next     = 1'b0;
            prune_countdown_next = '0;
          end else begin
            prune_countdown_next = timeout_seconds;
          end
        end
      end
      sbwa_pkg::OP_ADD: begin
        if (found) begin
          wr_en          = fire;
          wr_entry.addr  = item_addr;
          wr_entry.stamp = now_seconds;
          wr_entry.attempts = '0;
          verdict_next   = 1'b1;
        end else if (free_found) begin
          wr_en             = fire;
          wr_idx            = free_idx;
          wr_entry.addr     = item_addr;
          wr_entry.stamp    = now_seconds;
          wr_entry.attempts = '0;
          set_valid         = 1'b1;
          valid_total_next  = valid_total + 1'b1;
          verdict_next      = 1'b1;
          if (valid_total == '0) begin
            prune_armed_next     = 1'b1;
            prune_countdown_next = timeout_seconds;
          end
        end
      end
      sbwa_pkg::OP_CHECK: begin
        if (found) begin
          if (item_connect) begin
            wr_en             = fire;
            wr_entry.attempts = att_inc;
            verdict_next      = (att_inc <= max_attempts);
          end else begin
            verdict_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      timeout_seconds <= sbwa_pkg::TIMEOUT_RESET;
      max_attempts    <= sbwa_pkg::MAX_ATTEMPTS_RESET;
      entry_valid     <= '0;
      valid_total     <= '0;
      now_seconds     <= '0;
      prune_countdown <= '0;
      prune_armed     <= 1'b0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sbwa_pkg::REG_TIMEOUT:      timeout_seconds <= cfg_data;
          sbwa_pkg::REG_MAX_ATTEMPTS: max_attempts    <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item_op      <= operation;
            item_addr    <= station_addr;
            item_connect <= connect_request;
            pruning      <= 1'b0;
            scan_idx     <= '0;
            pend         <= 1'b0;
            found        <= 1'b0;
            free_found   <= 1'b0;
            removed      <= '0;
            state        <= S_DONE;
            if (operation == sbwa_pkg::OP_TICK) begin
              now_seconds <= now_seconds + 1'b1;
              if (prune_armed) begin
                if (prune_countdown <= sbwa_pkg::REG_W'(1)) begin
                  prune_countdown <= '0;
                  pruning         <= 1'b1;
                  state           <= S_SCAN;
                end else begin
                  prune_countdown <= prune_countdown - 1'b1;
                end
              end
            end else if (operation == sbwa_pkg::OP_ADD ||
                         operation == sbwa_pkg::OP_CHECK) begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // issue one read per cycle; examine the previous read's data
          if (rd_en) begin
            scan_idx <= scan_idx + 1'b1;
            pend_idx <= rd_idx;
          end
          pend <= rd_en;
          if (pend) begin
            if (pruning) begin
              if (entry_valid[pend_idx] &&
                  age >= sbwa_pkg::STAMP_W'(timeout_seconds)) begin
                entry_valid[pend_idx] <= 1'b0;
                removed               <= removed + 1'b1;
              end
            end else begin
              if (addr_hit && !found) begin
                found       <= 1'b1;
                found_idx   <= pend_idx;
                found_entry <= rd_entry;
              end
              if (!entry_valid[pend_idx] && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= pend_idx;
              end
            end
          end else if (!rd_en) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (fire) begin
            if (set_valid) begin
              entry_valid[free_idx] <= 1'b1;
            end
            valid_total     <= valid_total_next;
            prune_armed     <= prune_armed_next;
            prune_countdown <= prune_countdown_next;
            out_valid       <= 1'b1;
            verdict         <= verdict_next;
            entry_count     <= sbwa_pkg::COUNT_W'(valid_total_next);
            removed_count   <= pruning ? sbwa_pkg::COUNT_W'(removed) : '0;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_station_blocklist_with_aging.sv =====
module tb_station_blocklist_with_aging;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [sbwa_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = sbwa_pkg::CFG_INDEX_W'(2);
  localparam logic [sbwa_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = sbwa_pkg::CFG_INDEX_W'(3);
  localparam int POOL_SIZE = 48;
  localparam int SETTLE_CYCLES = sbwa_pkg::DEPTH + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic                         verdict;
    logic [sbwa_pkg::COUNT_W-1:0] entries;
    logic [sbwa_pkg::COUNT_W-1:0] removed;
  } outcome_t;

  // Shadow of the block list: predicts one outcome per input beat.
  class blocklist_shadow;
    logic [sbwa_pkg::REG_W-1:0]   timeout_s;
    logic [sbwa_pkg::REG_W-1:0]   max_tries;
    bit                           slot_valid[sbwa_pkg::DEPTH];
    logic [sbwa_pkg::ADDR_W-1:0]  slot_addr[sbwa_pkg::DEPTH];
    logic [sbwa_pkg::STAMP_W-1:0] slot_stamp[sbwa_pkg::DEPTH];
    logic [sbwa_pkg::ATT_W-1:0]   slot_tries[sbwa_pkg::DEPTH];
    int unsigned                  live;
    logic [sbwa_pkg::STAMP_W-1:0] now_s;
    logic [sbwa_pkg::REG_W-1:0]   countdown;
    bit                           armed;
    outcome_t                     due_outcomes[$];
    int                           errors;
    int                           results_seen;

    function new();
      timeout_s = sbwa_pkg::TIMEOUT_RESET;
      max_tries = sbwa_pkg::MAX_ATTEMPTS_RESET;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      live = 0;
      now_s = '0;
      countdown = '0;
      armed = 1'b0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [sbwa_pkg::CFG_INDEX_W-1:0] idx,
                            logic [sbwa_pkg::REG_W-1:0] data);
      if (idx == sbwa_pkg::REG_TIMEOUT) begin
        timeout_s = data;
      end else if (idx == sbwa_pkg::REG_MAX_ATTEMPTS) begin
        max_tries = data;
      end
    endfunction

    function int find_slot(logic [sbwa_pkg::ADDR_W-1:0] addr);
      int hit;
      hit = -1;
      for (int i = 0; i < sbwa_pkg::DEPTH && hit < 0; i++)
        if (slot_valid[i] && slot_addr[i] == addr) hit = i;
      return hit;
    endfunction

    function void note_item(logic [1:0] op, logic [sbwa_pkg::ADDR_W-1:0] addr, logic conn);
      outcome_t                     want;
      int                           slot;
      int unsigned                  pruned;
      logic [sbwa_pkg::STAMP_W-1:0] age;
      want = '0;
      pruned = 0;
      case (op)
        sbwa_pkg::OP_TICK: begin
          now_s = now_s + 1'b1;
          if (armed) begin
            if (countdown <= sbwa_pkg::REG_W'(1)) begin
              for (int i = 0; i < sbwa_pkg::DEPTH; i++) begin
                age = now_s - slot_stamp[i];
                if (slot_valid[i] && age >= sbwa_pkg::STAMP_W'(timeout_s)) begin
                  slot_valid[i] = 1'b0;
                  pruned++;
                end
              end
              live -= pruned;
              if (live == 0) begin
                armed = 1'b0;
                countdown = '0;
              end else begin
                countdown = timeout_s;
              end
            end else begin
              countdown = countdown - 1'b1;
            end
          end
        end
        sbwa_pkg::OP_ADD: begin
          slot = find_slot(addr);
          if (slot >= 0) begin
            slot_stamp[slot] = now_s;
            slot_tries[slot] = '0;
            want.verdict = 1'b1;
          end else if (live < sbwa_pkg::DEPTH) begin
            for (int i = 0; i < sbwa_pkg::DEPTH && slot < 0; i++)
              if (!slot_valid[i]) slot = i;
            slot_valid[slot] = 1'b1;
            slot_addr[slot] = addr;
            slot_stamp[slot] = now_s;
            slot_tries[slot] = '0;
            live++;
            if (live == 1) begin
              armed = 1'b1;
              countdown = timeout_s;
            end
            want.verdict = 1'b1;
          end
        end
        sbwa_pkg::OP_CHECK: begin
          slot = find_slot(addr);
          if (slot >= 0) begin
            if (conn) begin
              if (slot_tries[slot] != sbwa_pkg::ATT_MAX)
                slot_tries[slot] = slot_tries[slot] + 1'b1;
              want.verdict = (slot_tries[slot] <= max_tries);
            end else begin
              want.verdict = 1'b1;
            end
          end
        end
        default: ;
      endcase
      want.entries = sbwa_pkg::COUNT_W'(live);
      want.removed = sbwa_pkg::COUNT_W'(pruned);
      due_outcomes.push_back(want);
    endfunction

    function int pending();
      return due_outcomes.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_outcome(logic v, logic [sbwa_pkg::COUNT_W-1:0] ec,
                       logic [sbwa_pkg::COUNT_W-1:0] rc);
      outcome_t want;
      results_seen++;
      if (due_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", results_seen));
      end else begin
        want = due_outcomes.pop_front();
        if (v !== want.verdict)
          report_mismatch($sformatf("result %0d verdict %b, want %b",
                                    results_seen, v, want.verdict));
        if (ec !== want.entries)
          report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                    results_seen, ec, want.entries));
        if (rc !== want.removed)
          report_mismatch($sformatf("result %0d removed_count %0d, want %0d",
                                    results_seen, rc, want.removed));
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic [1:0]                       operation;
  logic [sbwa_pkg::ADDR_W-1:0]      station_addr;
  logic                             connect_request;
  logic                             out_valid;
  logic                             out_ready;
  logic                             verdict;
  logic [sbwa_pkg::COUNT_W-1:0]     entry_count;
  logic [sbwa_pkg::COUNT_W-1:0]     removed_count;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [sbwa_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sbwa_pkg::REG_W-1:0]       cfg_data;

  blocklist_shadow             board;
  logic [sbwa_pkg::ADDR_W-1:0] station_pool[POOL_SIZE];
  bit                          calm;
  int                          cycles;

  station_blocklist_with_aging DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .station_addr    (station_addr),
    .connect_request (connect_request),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .verdict         (verdict),
    .entry_count     (entry_count),
    .removed_count   (removed_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("station_blocklist_with_aging regression: fail");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off so the input backs up.
  initial begin : result_sink
    int gap_left;
    int hold_left;
    int rate;
    bit held;
    gap_left = 0;
    hold_left = 0;
    rate = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_outcome(verdict, entry_count, removed_count);
      if (cycles % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: rate = 0;
          1: rate = 8;
          default: rate = 25;
        endcase
      end
      if (!held && board.results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(1, 100) <= rate) begin
        gap_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // valid stays up across back-to-back beats; only pauses and settle drop it
  task automatic send_item(input logic [1:0] op, input logic [sbwa_pkg::ADDR_W-1:0] addr,
                           input logic conn);
    in_valid <= 1'b1;
    operation <= op;
    station_addr <= addr;
    connect_request <= conn;
    do @(posedge clk); while (!in_ready);
    board.note_item(op, addr, conn);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // spare indexes go last so an aliasing decode would show up
  task automatic configure(input logic [sbwa_pkg::REG_W-1:0] tmo,
                           input logic [sbwa_pkg::REG_W-1:0] tries, input bit spare);
    logic [sbwa_pkg::CFG_INDEX_W-1:0] idx[$];
    logic [sbwa_pkg::REG_W-1:0]       val[$];
    idx.push_back(sbwa_pkg::REG_TIMEOUT);
    val.push_back(tmo);
    idx.push_back(sbwa_pkg::REG_MAX_ATTEMPTS);
    val.push_back(tries);
    if (spare) begin
      idx.push_back(REG_SPARE_LO);
      val.push_back(sbwa_pkg::REG_W'($urandom));
      idx.push_back(REG_SPARE_HI);
      val.push_back(sbwa_pkg::REG_W'($urandom));
    end
    foreach (idx[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
      board.write_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int items, input int tick_pct, input int add_pct,
                           input int calm_from);
    int                          roll;
    int                          gap_pct;
    logic [1:0]                  op;
    logic [sbwa_pkg::ADDR_W-1:0] addr;
    gap_pct = 0;
    for (int k = 0; k < items; k++) begin
      if (k == calm_from) calm = 1'b1;
      if (k % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 35;
        endcase
      end
      if (!calm && $urandom_range(1, 100) <= gap_pct) pause_sender($urandom_range(1, 18));
      roll = $urandom_range(1, 100);
      if (roll <= tick_pct) op = sbwa_pkg::OP_TICK;
      else if (roll <= tick_pct + add_pct) op = sbwa_pkg::OP_ADD;
      else op = sbwa_pkg::OP_CHECK;
      // mostly pool hits so refreshes, attempt counts and a full table all occur
      if ($urandom_range(0, 9) == 0) addr = sbwa_pkg::ADDR_W'({$urandom, $urandom});
      else addr = station_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_item(op, addr, 1'($urandom));
    end
  endtask

  initial begin
    logic [sbwa_pkg::ADDR_W-1:0] lo_addr;
    logic [sbwa_pkg::ADDR_W-1:0] hi_addr;
    board = new();
    calm = 1'b0;
    lo_addr = '0;
    hi_addr = '1;
    station_pool[0] = lo_addr;
    station_pool[1] = hi_addr;
    for (int i = 2; i < POOL_SIZE; i++)
      station_pool[i] = sbwa_pkg::ADDR_W'({$urandom, $urandom});

    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= sbwa_pkg::OP_TICK;
    station_addr <= '0;
    connect_request <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= sbwa_pkg::REG_TIMEOUT;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    send_item(sbwa_pkg::OP_CHECK, hi_addr, 1'b1);            // unknown station
    send_item(sbwa_pkg::OP_TICK, lo_addr, 1'b0);             // timer not armed yet
    send_item(sbwa_pkg::OP_ADD, lo_addr, 1'b0);              // first entry arms the timer
    send_item(sbwa_pkg::OP_ADD, hi_addr, 1'b0);
    send_item(sbwa_pkg::OP_ADD, lo_addr, 1'b0);              // refresh
    send_item(sbwa_pkg::OP_CHECK, hi_addr, 1'b0);
    repeat (4) send_item(sbwa_pkg::OP_CHECK, hi_addr, 1'b1); // attempts pass the limit
    send_item(sbwa_pkg::OP_ADD, hi_addr, 1'b1);              // refresh clears attempts
    send_item(sbwa_pkg::OP_CHECK, hi_addr, 1'b1);
    send_item(OP_NONE, hi_addr, 1'b1);
    send_item(sbwa_pkg::OP_ADD, sbwa_pkg::ADDR_W'(48'hAAAA_AAAA_AAAA), 1'b0);
    send_item(sbwa_pkg::OP_CHECK, sbwa_pkg::ADDR_W'(48'h5555_5555_5555), 1'b1);
    send_item(sbwa_pkg::OP_TICK, hi_addr, 1'b1);

    settle();
    configure(sbwa_pkg::REG_W'(1), sbwa_pkg::REG_W'(1), 1'b0);
    run_phase(200, 45, 30, 200);

    settle();
    configure(sbwa_pkg::REG_W'(4), sbwa_pkg::REG_W'(2), 1'b1);
    run_phase(220, 35, 35, 220);

    settle();
    configure(sbwa_pkg::REG_W'($urandom_range(2, 12)),
              sbwa_pkg::REG_W'($urandom_range(1, 6)), 1'b0);
    run_phase(280, 30, 40, 280);

    // widest settings, add-heavy so the table fills up
    settle();
    configure(sbwa_pkg::REG_W'(16'hFFFF), sbwa_pkg::REG_W'(16'hFFFF), 1'b1);
    run_phase(300, 15, 55, 150);

    settle();
    if (board.errors == 0)
      $display("station_blocklist_with_aging regression: pass");
    else
      $display("station_blocklist_with_aging regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sbwa_pkg.sv
hdl/station_blocklist_with_aging.sv
tb/tb_station_blocklist_with_aging.sv
